// ===== hw/rtl/iirlp_pkg.sv =====
// Shared constants and the coefficient scaling function of the fourth-order
// low-pass with threshold and change reporting. No dependencies.
package iirlp_pkg;

    localparam int SAMPLE_BITS_DEF    = 10;
    localparam int COEF_FRAC_BITS_DEF = 28;
    localparam int THRESH_BITS        = 10;
    localparam int REF_FRAC_BITS      = 30;

    // Butterworth numerator and denominator (a1..a4), scaled by 2^30.
    localparam longint NUM30 [5] = '{
        64'sd447320, 64'sd1789280, 64'sd2683920, 64'sd1789280, 64'sd447320
    };
    localparam longint DEN30 [4] = '{
        -64'sd3415184637, 64'sd4145925863, -64'sd2267909544, 64'sd470583613
    };

    // Reduces a 2^30-scaled coefficient to frac_bits fraction bits, rounding
    // half up on the magnitude.
    function automatic longint scale_coef(input longint c30, input int frac_bits);
        longint mag;
        int     sh;
        mag = (c30 < 0) ? -c30 : c30;
        sh  = REF_FRAC_BITS - frac_bits;
        if (sh > 0) begin
            mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        end
        return (c30 < 0) ? -mag : mag;
    endfunction

endpackage

// ===== hw/rtl/iirlp_filter.sv =====
// Direct form I filter datapath: sample and output histories, nine coefficient
// terms and the saturating sum. Depends on iirlp_pkg.
module iirlp_filter #(
    parameter int SAMPLE_BITS    = iirlp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = iirlp_pkg::COEF_FRAC_BITS_DEF,
    localparam int HW            = SAMPLE_BITS + COEF_FRAC_BITS + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [SAMPLE_BITS-1:0] i_x,
    output logic signed [HW-1:0]   o_y
);

    localparam int F    = COEF_FRAC_BITS;
    localparam int CW   = F + 3;
    localparam int HIW  = SAMPLE_BITS + 2;
    localparam int BPW  = CW + SAMPLE_BITS + 1;
    localparam int PHW  = CW + HIW;
    localparam int PLW  = CW + F + 1;
    localparam int ACCW = HW + 6;

    localparam logic signed [CW-1:0] BCOEF [5] = '{
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::NUM30[0], F)),
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::NUM30[1], F)),
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::NUM30[2], F)),
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::NUM30[3], F)),
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::NUM30[4], F))
    };
    localparam logic signed [CW-1:0] ACOEF [4] = '{
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::DEN30[0], F)),
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::DEN30[1], F)),
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::DEN30[2], F)),
        CW'(iirlp_pkg::scale_coef(iirlp_pkg::DEN30[3], F))
    };
    localparam logic signed [ACCW-1:0] SAT_HI = {{(ACCW-HW+1){1'b0}}, {(HW-1){1'b1}}};
    localparam logic signed [ACCW-1:0] SAT_LO = ~SAT_HI;

    logic        [SAMPLE_BITS-1:0] r_xh [4];
    logic signed [HW-1:0]          r_yh [4];

    logic signed [SAMPLE_BITS:0]   xs  [5];
    logic signed [BPW-1:0]         bx  [5];
    logic signed [HIW-1:0]         yhi [4];
    logic signed [F:0]             ylo [4];
    logic signed [PHW-1:0]         ph  [4];
    logic signed [PLW-1:0]         pl  [4];
    logic signed [ACCW-1:0]        acc;

    always_comb begin
        xs[0] = $signed({1'b0, i_x});
        for (int k = 0; k < 4; k++) begin
            xs[k+1] = $signed({1'b0, r_xh[k]});
            yhi[k]  = $signed(r_yh[k][HW-1:F]);
            ylo[k]  = $signed({1'b0, r_yh[k][F-1:0]});
        end
        acc = '0;
        for (int k = 0; k < 5; k++) begin
            bx[k] = BCOEF[k] * xs[k];
            acc   = acc + ACCW'(bx[k]);
        end
        for (int k = 0; k < 4; k++) begin
            ph[k] = ACOEF[k] * yhi[k];
            pl[k] = ACOEF[k] * ylo[k];
            acc   = acc - ACCW'(ph[k]) - ACCW'($signed(pl[k][PLW-1:F]));
        end
        if (acc > SAT_HI) begin
            o_y = SAT_HI[HW-1:0];
        end else if (acc < SAT_LO) begin
            o_y = SAT_LO[HW-1:0];
        end else begin
            o_y = acc[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_xh[k] <= '0;
                r_yh[k] <= '0;
            end
        end else if (i_step) begin
            r_xh[0] <= i_x;
            r_yh[0] <= o_y;
            for (int k = 1; k < 4; k++) begin
                r_xh[k] <= r_xh[k-1];
                r_yh[k] <= r_yh[k-1];
            end
        end
    end

`ifndef SYNTHESIS
    a_hist_shift : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_xh[0] == $past(i_x)) && (r_yh[0] == $past(o_y))
                   && (r_xh[1] == $past(r_xh[0])))
        else $error("filter history did not advance");
`endif

endmodule

// ===== hw/rtl/iirlp_report.sv =====
// Integer conversion, threshold, change detection and the output register.
// Depends on iirlp_pkg.
module iirlp_report #(
    parameter int SAMPLE_BITS    = iirlp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = iirlp_pkg::COEF_FRAC_BITS_DEF,
    localparam int HW            = SAMPLE_BITS + COEF_FRAC_BITS + 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic signed [HW-1:0]             i_y,
    input  logic [iirlp_pkg::THRESH_BITS-1:0] i_threshold,
    output logic                             o_free,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [SAMPLE_BITS-1:0]           o_value
);

    localparam int CMPW = SAMPLE_BITS + iirlp_pkg::THRESH_BITS;

    logic [SAMPLE_BITS:0]   ipart;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [SAMPLE_BITS-1:0] n_value;
    logic                   changed;
    logic [SAMPLE_BITS-1:0] r_last;
    logic [SAMPLE_BITS-1:0] r_out;
    logic                   r_out_vld;

    always_comb begin
        ipart = i_y[HW-2:COEF_FRAC_BITS];
        if (i_y[HW-1]) begin
            clamped = '0;
        end else if (ipart[SAMPLE_BITS]) begin
            clamped = '1;
        end else begin
            clamped = ipart[SAMPLE_BITS-1:0];
        end
        if (CMPW'(clamped) < CMPW'(i_threshold)) begin
            n_value = '0;
        end else begin
            n_value = clamped;
        end
        changed = (n_value != r_last);
    end

    assign o_free  = !r_out_vld || i_ready;
    assign o_valid = r_out_vld;
    assign o_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_out_vld <= 1'b0;
        end else if (i_advance && changed) begin
            r_last    <= n_value;
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && changed) begin
            r_out <= n_value;
        end
    end

`ifndef SYNTHESIS
    a_pending_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out == r_last))
        else $error("pending result differs from last reported value");
    a_change_emits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && changed) |=> r_out_vld)
        else $error("changed value was not presented");
`endif

endmodule

// ===== hw/rtl/iir_lowpass_threshold_change_report.sv =====
// Top level of the fourth-order low-pass with threshold and change reporting:
// configuration register and input register. Depends on iirlp_pkg,
// iirlp_filter and iirlp_report.
//
//  Channel  Direction  Handshake                   Payload
//  in       to block   i_in_valid / o_in_ready     i_sample_in
//  out      from block o_out_valid / i_out_ready   o_filtered_value
//  cfg      to block   i_cfg_valid / o_cfg_ready   i_level_threshold
//
// One sample is accepted per cycle unless the output stalls. A result is
// registered from the input register, only if its value changed. The filter
// feedback closes through the output history register. Reset is synchronous
// and clears histories, threshold and last value. A stalled output holds the
// sample in the input register, and input ready then follows output ready.
module iir_lowpass_threshold_change_report #(
    parameter int SAMPLE_BITS    = iirlp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = iirlp_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [iirlp_pkg::THRESH_BITS-1:0] i_level_threshold,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [SAMPLE_BITS-1:0]            i_sample_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [SAMPLE_BITS-1:0]            o_filtered_value
);

    localparam int HW = SAMPLE_BITS + COEF_FRAC_BITS + 2;

    logic [iirlp_pkg::THRESH_BITS-1:0] r_threshold;
    logic [SAMPLE_BITS-1:0]            r_x;
    logic                              r_x_vld;
    logic                              advance;
    logic                              out_free;
    logic signed [HW-1:0]              y;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_x_vld && out_free;
    assign o_in_ready  = !r_x_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_valid) begin
            r_threshold <= i_level_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_x_vld <= 1'b1;
        end else if (advance) begin
            r_x_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_x <= i_sample_in;
        end
    end

    iirlp_filter #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_x     (r_x),
        .o_y     (y)
    );

    iirlp_report #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_y         (y),
        .i_threshold (r_threshold),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_value     (o_filtered_value)
    );

`ifndef SYNTHESIS
    a_held_sample : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x_vld && !advance) |=> (r_x_vld && $stable(r_x)))
        else $error("stalled sample was lost or changed");
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_x_vld |-> o_in_ready)
        else $error("empty input register refused a sample");
`endif

endmodule

// ===== tb/sv/tb_iir_lowpass_threshold_change_report.sv =====
// Self-checking testbench for the fourth-order low-pass with threshold and change
// reporting: a queue-fed sample driver, random output stalls and a bit-exact predictor.
// Depends on iirlp_pkg and iir_lowpass_threshold_change_report.
module tb_iir_lowpass_threshold_change_report;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB   = iirlp_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC = iirlp_pkg::COEF_FRAC_BITS_DEF;
    localparam int TB   = iirlp_pkg::THRESH_BITS;

    // Q3.28 coefficients: the published values times 2^28, magnitude rounded half up.
    localparam longint NUM_Q28 [5] = '{
        64'sd111830, 64'sd447320, 64'sd670980, 64'sd447320, 64'sd111830
    };
    localparam longint DEN_Q28 [4] = '{
        -64'sd853796159, 64'sd1036481466, -64'sd566977386, 64'sd117645903
    };
    localparam logic signed [79:0] HIST_MAX = 80'sd1 <<< (SB + 1 + FRAC);
    localparam logic signed [79:0] TOP_MAX  = 80'sd1 <<< (SB + FRAC);

    typedef struct {
        logic [SB-1:0] sample;
        int            gap;
        bit            drain_first;
    } t_sample_item;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [TB-1:0] i_level_threshold = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [SB-1:0] i_sample_in = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b1;
    logic [SB-1:0] o_filtered_value;

    t_sample_item  sample_q [$];
    logic [SB-1:0] due_values [$];
    longint        x_hist [4] = '{0, 0, 0, 0};
    longint        y_hist [4] = '{0, 0, 0, 0};
    logic [SB-1:0] last_sent = '0;
    logic [TB-1:0] thr_model = '0;
    bit            in_acc_seen = 1'b0;
    bit            cfg_acc_seen = 1'b0;
    bit            calm = 1'b1;
    int            items_pushed = 0;
    int            items_taken = 0;
    int            errors = 0;
    int            tx_wait = 0;
    int            rx_hold = 0;

    iir_lowpass_threshold_change_report i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_level_threshold(i_level_threshold),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_in      (i_sample_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_value (o_filtered_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SB-1:0] pick_level();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return SB'($urandom_range(0, (1 << SB) - 1));
    endfunction

    // Runs one sample through the filter and queues the value it reports, if any.
    function automatic void lowpass_predict(input logic [SB-1:0] x);
        logic signed [79:0] acc;
        logic signed [79:0] prod;
        logic [SB-1:0]      v;
        int                 i;
        acc = NUM_Q28[0] * longint'(x);
        for (i = 0; i < 4; i++) begin
            acc = acc + NUM_Q28[i + 1] * x_hist[i];
        end
        for (i = 0; i < 4; i++) begin
            prod = DEN_Q28[i] * y_hist[i];
            acc  = acc - (prod >>> FRAC);
        end
        if (acc >= HIST_MAX) begin
            acc = HIST_MAX - 1;
        end
        if (acc < -HIST_MAX) begin
            acc = -HIST_MAX;
        end
        for (i = 3; i > 0; i--) begin
            x_hist[i] = x_hist[i - 1];
            y_hist[i] = y_hist[i - 1];
        end
        x_hist[0] = longint'(x);
        y_hist[0] = longint'(acc);
        if (acc < 0) begin
            v = '0;
        end else if (acc >= TOP_MAX) begin
            v = '1;
        end else begin
            v = acc[FRAC +: SB];
        end
        if (v < thr_model) begin
            v = '0;
        end
        if (v != last_sent) begin
            last_sent = v;
            due_values.push_back(v);
        end
    endfunction

    // Monitor: results are checked before the new transaction is predicted.
    always @(posedge i_clk) begin
        logic [SB-1:0] want;
        in_acc_seen  <= i_rst_n && i_in_valid && o_in_ready;
        cfg_acc_seen <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_values.size() == 0) begin
                    $display("%t unexpected filtered_value: expected none, actual %0d",
                             $time, o_filtered_value);
                    errors++;
                end else begin
                    want = due_values.pop_front();
                    if (o_filtered_value !== want) begin
                        $display("%t filtered_value mismatch: expected %0d, actual %0d",
                                 $time, want, o_filtered_value);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                thr_model = i_level_threshold;
            end
            if (i_in_valid && o_in_ready) begin
                items_taken++;
                lowpass_predict(i_sample_in);
            end
        end
    end

    always @(negedge i_clk) begin
        t_sample_item it;
        logic         v;
        v = i_in_valid;
        if (in_acc_seen) begin
            v = 1'b0;
        end
        if (i_rst_n && !v && sample_q.size() > 0) begin
            if (tx_wait < sample_q[0].gap) begin
                tx_wait++;
            end else if (!(sample_q[0].drain_first && due_values.size() > 0)) begin
                it          = sample_q.pop_front();
                tx_wait     = 0;
                v           = 1'b1;
                i_sample_in <= it.sample;
            end
        end
        i_in_valid <= v;
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) begin
                rx_hold = pick_gap();
            end
        end
    end

    task automatic push_sample(input logic [SB-1:0] s, input bit drain);
        t_sample_item it;
        it.sample      = s;
        it.gap         = calm ? 0 : pick_gap();
        it.drain_first = drain;
        sample_q.push_back(it);
        items_pushed++;
    endtask

    task automatic wait_drained();
        while (items_taken != items_pushed || due_values.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [TB-1:0] value);
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_level_threshold <= value;
        do @(negedge i_clk); while (!cfg_acc_seen);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly held levels long enough for the filter to settle, with noise and
    // full-scale toggling mixed in.
    task automatic random_samples(input int count);
        int            n;
        int            len;
        int            kind;
        int            k;
        logic [SB-1:0] level;
        n = 0;
        while (n < count) begin
            kind  = $urandom_range(0, 9);
            level = pick_level();
            len   = (kind < 7) ? $urandom_range(8, 60) : $urandom_range(4, 16);
            if (len > count - n) begin
                len = count - n;
            end
            for (k = 0; k < len; k++) begin
                if (kind == 7 || kind == 8) begin
                    level = SB'($urandom_range(0, (1 << SB) - 1));
                end else if (kind == 9) begin
                    level = (k % 2 == 0) ? '1 : '0;
                end
                push_sample(level, k == 0 && $urandom_range(0, 14) == 0);
            end
            n += len;
        end
    endtask

    initial begin
        int k;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_threshold('0);
        push_sample('1, 1'b0);
        push_sample('1, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);
        for (k = 0; k < 12; k++) begin
            push_sample('1, k == 6);
        end
        for (k = 0; k < 7; k++) begin
            push_sample('0, 1'b0);
        end
        wait_drained();

        calm = 1'b0;
        write_threshold('1);
        random_samples(150);
        wait_drained();

        write_threshold(TB'($urandom_range(2, (1 << TB) - 2)));
        random_samples(150);
        wait_drained();

        write_threshold(TB'(1));
        random_samples(150);
        wait_drained();

        calm = 1'b1;
        write_threshold(TB'(512));
        random_samples(150);
        wait_drained();

        calm = 1'b0;
        write_threshold('0);
        random_samples(150);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (errors == 0 && due_values.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
